// ----- sv/sbv_pkg.sv -----
// ----------------------------------------------------------------------------
// sbv_pkg
// Shared types and constants of the bit-vector ALU.
// ----------------------------------------------------------------------------
package sbv_pkg;

    localparam int unsigned DEF_WIDTH = 32;
    localparam int unsigned CMD_W     = 6;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned QDEPTH    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOT    = 6'd0,
        CMD_AND    = 6'd1,
        CMD_OR     = 6'd2,
        CMD_XOR    = 6'd3,
        CMD_NAND   = 6'd4,
        CMD_NOR    = 6'd5,
        CMD_XNOR   = 6'd6,
        CMD_NEG    = 6'd7,
        CMD_ADD    = 6'd8,
        CMD_SUB    = 6'd9,
        CMD_MUL    = 6'd10,
        CMD_UDIV   = 6'd11,
        CMD_UREM   = 6'd12,
        CMD_SDIV   = 6'd13,
        CMD_SREM   = 6'd14,
        CMD_SMOD   = 6'd15,
        CMD_SHL    = 6'd16,
        CMD_LSHR   = 6'd17,
        CMD_ASHR   = 6'd18,
        CMD_ROTL   = 6'd19,
        CMD_ROTR   = 6'd20,
        CMD_ULT    = 6'd21,
        CMD_ULE    = 6'd22,
        CMD_UGT    = 6'd23,
        CMD_UGE    = 6'd24,
        CMD_SLT    = 6'd25,
        CMD_SLE    = 6'd26,
        CMD_SGT    = 6'd27,
        CMD_SGE    = 6'd28,
        CMD_EQ     = 6'd29,
        CMD_REDAND = 6'd30,
        CMD_REDOR  = 6'd31,
        CMD_NEGO   = 6'd32,
        CMD_UADDO  = 6'd33,
        CMD_SADDO  = 6'd34,
        CMD_UMULO  = 6'd35,
        CMD_SMULO  = 6'd36,
        CMD_USUBO  = 6'd37,
        CMD_SSUBO  = 6'd38,
        CMD_SDIVO  = 6'd39
    } t_cmd;

    // what the multiplier result is used for in the final stage
    typedef enum logic [1:0] {
        MK_NONE  = 2'd0,
        MK_MUL   = 2'd1,
        MK_UMULO = 2'd2,
        MK_SMULO = 2'd3
    } t_mk;

    typedef struct packed {
        t_cmd cmd;
        logic is_div;
    } t_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_div_stat;

endpackage

// ----- sv/sbv_front.sv -----
// ----------------------------------------------------------------------------
// sbv_front
// Input stage: masks operands, classifies the command, reduces the rotate
// amount modulo WIDTH and queues items for the execution side.
// ----------------------------------------------------------------------------
module sbv_front
    import sbv_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH,
    localparam int unsigned KW   = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [WORD_W-1:0]    i_operand_a,
    input  logic [WORD_W-1:0]    i_operand_b,
    output logic                 o_head_v,
    output t_ctl                 o_head_ctl,
    output logic [WIDTH-1:0]     o_head_a,
    output logic [WIDTH-1:0]     o_head_b,
    output logic [KW-1:0]        o_head_k,
    input  logic                 i_head_pop
);

    localparam longint unsigned RECIP_L = (64'd1 << 32) / WIDTH;
    localparam logic [32:0]     RECIP   = 33'(RECIP_L);
    localparam logic [31:0]     MASK32  = (WIDTH >= 32) ? 32'hFFFF_FFFF
                                                        : 32'((64'd1 << WIDTH) - 64'd1);
    localparam logic [6:0]      W7      = 7'(WIDTH);
    localparam int unsigned     QPW     = $clog2(QDEPTH);

    logic [31:0]      a32;
    logic [31:0]      b32;
    logic [64:0]      rprod;
    t_ctl             in_ctl;
    logic             acc;
    logic             wr;
    logic             q_full;

    logic             r_f1_v;
    t_ctl             r_f1_ctl;
    logic [WIDTH-1:0] r_f1_a;
    logic [WIDTH-1:0] r_f1_b;
    logic [6:0]       r_f1_bl;
    logic [6:0]       r_f1_qe;

    logic [6:0]       k_est;
    logic [6:0]       k_fix;

    t_ctl             r_q_ctl [QDEPTH];
    logic [WIDTH-1:0] r_q_a   [QDEPTH];
    logic [WIDTH-1:0] r_q_b   [QDEPTH];
    logic [KW-1:0]    r_q_k   [QDEPTH];
    logic [QPW-1:0]   r_wp;
    logic [QPW-1:0]   r_rp;
    logic [QPW:0]     r_cnt;

    assign a32 = i_operand_a & MASK32;
    assign b32 = i_operand_b & MASK32;

    // quotient estimate of b / WIDTH, low or exact by one
    assign rprod = 65'(b32) * 65'(RECIP);

    always_comb begin
        in_ctl.cmd    = t_cmd'(i_cmd);
        in_ctl.is_div = (in_ctl.cmd == CMD_UDIV) || (in_ctl.cmd == CMD_UREM) ||
                        (in_ctl.cmd == CMD_SDIV) || (in_ctl.cmd == CMD_SREM) ||
                        (in_ctl.cmd == CMD_SMOD);
    end

    assign q_full = (r_cnt == (QPW+1)'(QDEPTH));
    assign wr     = r_f1_v && !q_full;
    assign full   = r_f1_v && !wr;
    assign acc    = push && !full;

    // remainder only needs the low seven bits, it is below 2*WIDTH
    assign k_est = 7'(r_f1_bl - 7'(r_f1_qe * W7));
    assign k_fix = (k_est >= W7) ? 7'(k_est - W7) : k_est;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (acc) begin
            r_f1_v <= 1'b1;
        end else if (wr) begin
            r_f1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_f1_ctl <= in_ctl;
            r_f1_a   <= WIDTH'(a32);
            r_f1_b   <= WIDTH'(b32);
            r_f1_bl  <= b32[6:0];
            r_f1_qe  <= rprod[38:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= QPW'(r_wp + 1'b1);
            end
            if (i_head_pop) begin
                r_rp <= QPW'(r_rp + 1'b1);
            end
            r_cnt <= (QPW+1)'(r_cnt + (QPW+1)'(wr) - (QPW+1)'(i_head_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q_ctl[r_wp] <= r_f1_ctl;
            r_q_a[r_wp]   <= r_f1_a;
            r_q_b[r_wp]   <= r_f1_b;
            r_q_k[r_wp]   <= k_fix[KW-1:0];
        end
    end

    assign o_head_v   = (r_cnt != '0);
    assign o_head_ctl = r_q_ctl[r_rp];
    assign o_head_a   = r_q_a[r_rp];
    assign o_head_b   = r_q_b[r_rp];
    assign o_head_k   = r_q_k[r_rp];

endmodule

// ----- sv/sbv_div.sv -----
// ----------------------------------------------------------------------------
// sbv_div
// Iterative restoring divider, one quotient bit per cycle, with the signed
// fixups and the division by zero and overflow cases.
// ----------------------------------------------------------------------------
module sbv_div
    import sbv_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_cmd             i_cmd,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output t_div_stat        o_stat,
    output logic [WIDTH-1:0] o_res,
    input  logic             i_take
);

    localparam int unsigned      CW   = $clog2(WIDTH + 1);
    localparam logic [WIDTH-1:0] SBIT = WIDTH'(1) << (WIDTH - 1);

    typedef enum logic [4:0] {
        DIV_IDLE = 5'b00001,
        DIV_RUN  = 5'b00010,
        DIV_FIX  = 5'b00100,
        DIV_ADJ  = 5'b01000,
        DIV_DONE = 5'b10000
    } t_div_state;

    t_div_state       r_state;
    t_div_state       n_state;
    t_cmd             r_cmd;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_mb;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_res;
    logic [CW-1:0]    r_cnt;
    logic             r_nq;
    logic             r_nr;
    logic             r_bz;
    logic             r_ovf;

    logic             sgn;
    logic [WIDTH-1:0] ma;
    logic [WIDTH-1:0] mb;
    logic [WIDTH:0]   t;
    logic             ge;
    logic [WIDTH:0]   t_sub;
    logic [WIDTH:0]   quo_sh;
    logic [WIDTH-1:0] q_s;
    logic [WIDTH-1:0] r_s;
    logic [WIDTH-1:0] fix_res;

    assign sgn = (i_cmd == CMD_SDIV) || (i_cmd == CMD_SREM) || (i_cmd == CMD_SMOD);
    assign ma  = (sgn && i_a[WIDTH-1]) ? WIDTH'(WIDTH'(0) - i_a) : i_a;
    assign mb  = (sgn && i_b[WIDTH-1]) ? WIDTH'(WIDTH'(0) - i_b) : i_b;

    assign t      = {r_rem, r_quo[WIDTH-1]};
    assign ge     = (t >= {1'b0, r_mb});
    assign t_sub  = t - {1'b0, r_mb};
    assign quo_sh = {r_quo, ge};

    assign q_s = r_nq ? WIDTH'(WIDTH'(0) - r_quo) : r_quo;
    assign r_s = r_nr ? WIDTH'(WIDTH'(0) - r_rem) : r_rem;

    always_comb begin
        case (r_cmd)
            CMD_UDIV: fix_res = r_quo;
            CMD_UREM: fix_res = r_rem;
            CMD_SDIV: fix_res = r_bz ? '1 : (r_ovf ? r_a : q_s);
            default:  fix_res = r_bz ? r_a : (r_ovf ? '0 : r_s);
        endcase
    end

    always_comb begin
        case (r_state)
            DIV_IDLE: n_state = i_start ? DIV_RUN : DIV_IDLE;
            DIV_RUN:  n_state = (r_cnt == CW'(1)) ? DIV_FIX : DIV_RUN;
            DIV_FIX:  n_state = DIV_ADJ;
            DIV_ADJ:  n_state = DIV_DONE;
            DIV_DONE: n_state = i_take ? DIV_IDLE : DIV_DONE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DIV_IDLE: begin
                if (i_start) begin
                    r_cmd <= i_cmd;
                    r_a   <= i_a;
                    r_b   <= i_b;
                    r_mb  <= mb;
                    r_quo <= ma;
                    r_rem <= '0;
                    r_cnt <= CW'(WIDTH);
                    r_nq  <= sgn && (i_a[WIDTH-1] != i_b[WIDTH-1]);
                    r_nr  <= sgn && i_a[WIDTH-1];
                    r_bz  <= (i_b == '0);
                    r_ovf <= sgn && (i_a == SBIT) && (&i_b);
                end
            end
            DIV_RUN: begin
                r_rem <= ge ? t_sub[WIDTH-1:0] : t[WIDTH-1:0];
                r_quo <= quo_sh[WIDTH-1:0];
                r_cnt <= CW'(r_cnt - 1'b1);
            end
            DIV_FIX: begin
                r_res <= fix_res;
            end
            DIV_ADJ: begin
                // floor modulo takes the sign of the divisor
                if ((r_cmd == CMD_SMOD) && !r_bz && !r_ovf && (r_res != '0) &&
                    (r_res[WIDTH-1] != r_b[WIDTH-1])) begin
                    r_res <= WIDTH'(r_res + r_b);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stat.idle = (r_state == DIV_IDLE);
    assign o_stat.done = (r_state == DIV_DONE);
    assign o_res       = r_res;

endmodule

// ----- sv/sbv_back.sv -----
// ----------------------------------------------------------------------------
// sbv_back
// Execution side: issues queued items, evaluates word and flag operations,
// runs the multiplier, hands division to the divider and queues results.
// ----------------------------------------------------------------------------
module sbv_back
    import sbv_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH,
    localparam int unsigned KW   = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_head_v,
    input  t_ctl              i_head_ctl,
    input  logic [WIDTH-1:0]  i_head_a,
    input  logic [WIDTH-1:0]  i_head_b,
    input  logic [KW-1:0]     i_head_k,
    output logic              o_head_pop,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] o_result_word,
    output logic              o_result_flag
);

    localparam int unsigned      MW   = (WIDTH < 32) ? WIDTH : 32;
    localparam int unsigned      PW   = 2 * MW + 2;
    localparam logic [WIDTH-1:0] SBIT = WIDTH'(1) << (WIDTH - 1);
    localparam int unsigned      QPW  = $clog2(QDEPTH);

    logic [WIDTH-1:0]  a;
    logic [WIDTH-1:0]  b;
    logic [WIDTH:0]    sum;
    logic [WIDTH:0]    diff;
    logic              ult;
    logic              slt;
    logic              eq;
    logic [KW:0]       rk;
    logic [WIDTH-1:0]  e_word;
    logic              e_flag;
    t_mk               e_mk;
    logic              m_ext_a;
    logic              m_ext_b;
    logic signed [MW:0] m_a;
    logic signed [MW:0] m_b;
    logic signed [PW-1:0] m_prod;

    t_div_stat         dstat;
    logic [WIDTH-1:0]  dres;
    logic              start_div;
    logic              issue;
    logic              div_take;
    logic              s1_ready;
    logic              s1_move;
    logic              out_room;

    logic              r_s1_v;
    t_mk               r_s1_mk;
    logic [WIDTH-1:0]  r_s1_word;
    logic              r_s1_flag;
    logic [PW-1:0]     r_s1_prod;

    logic [WIDTH-1:0]  f_word;
    logic              f_flag;

    logic [WORD_W-1:0] r_o_word [QDEPTH];
    logic              r_o_flag [QDEPTH];
    logic [QPW-1:0]    r_o_wp;
    logic [QPW-1:0]    r_o_rp;
    logic [QPW:0]      r_o_cnt;
    logic              o_pop;

    assign a = i_head_a;
    assign b = i_head_b;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = {1'b0, a} - {1'b0, b};
    assign ult  = diff[WIDTH];
    assign slt  = $signed(a) < $signed(b);
    assign eq   = (a == b);
    assign rk   = (KW+1)'(WIDTH) - {1'b0, i_head_k};

    // operands above 32 bits have a zero top, so the signed view only applies
    // at WIDTH of 32 or less
    assign m_ext_a = (WIDTH <= 32) && (i_head_ctl.cmd == CMD_SMULO) && a[MW-1];
    assign m_ext_b = (WIDTH <= 32) && (i_head_ctl.cmd == CMD_SMULO) && b[MW-1];
    assign m_a     = {m_ext_a, a[MW-1:0]};
    assign m_b     = {m_ext_b, b[MW-1:0]};
    assign m_prod  = m_a * m_b;

    always_comb begin
        e_word = '0;
        e_flag = 1'b0;
        e_mk   = MK_NONE;
        case (i_head_ctl.cmd)
            CMD_NOT:    e_word = ~a;
            CMD_AND:    e_word = a & b;
            CMD_OR:     e_word = a | b;
            CMD_XOR:    e_word = a ^ b;
            CMD_NAND:   e_word = ~(a & b);
            CMD_NOR:    e_word = ~(a | b);
            CMD_XNOR:   e_word = ~(a ^ b);
            CMD_NEG:    e_word = WIDTH'(WIDTH'(0) - a);
            CMD_ADD:    e_word = sum[WIDTH-1:0];
            CMD_SUB:    e_word = diff[WIDTH-1:0];
            CMD_MUL:    e_mk   = MK_MUL;
            CMD_SHL:    e_word = a << b;
            CMD_LSHR:   e_word = a >> b;
            CMD_ASHR:   e_word = WIDTH'($signed(a) >>> b);
            CMD_ROTL:   e_word = (a << i_head_k) | (a >> rk);
            CMD_ROTR:   e_word = (a >> i_head_k) | (a << rk);
            CMD_ULT:    e_flag = ult;
            CMD_ULE:    e_flag = ult || eq;
            CMD_UGT:    e_flag = !ult && !eq;
            CMD_UGE:    e_flag = !ult;
            CMD_SLT:    e_flag = slt;
            CMD_SLE:    e_flag = slt || eq;
            CMD_SGT:    e_flag = !slt && !eq;
            CMD_SGE:    e_flag = !slt;
            CMD_EQ:     e_flag = eq;
            CMD_REDAND: e_flag = &a;
            CMD_REDOR:  e_flag = |a;
            CMD_NEGO:   e_flag = (a == SBIT);
            CMD_UADDO:  e_flag = sum[WIDTH];
            CMD_SADDO:  e_flag = (a[WIDTH-1] == b[WIDTH-1]) && (sum[WIDTH-1] != a[WIDTH-1]);
            CMD_UMULO:  e_mk   = MK_UMULO;
            CMD_SMULO:  e_mk   = MK_SMULO;
            CMD_USUBO:  e_flag = ult;
            CMD_SSUBO:  e_flag = (a[WIDTH-1] != b[WIDTH-1]) && (diff[WIDTH-1] != a[WIDTH-1]);
            CMD_SDIVO:  e_flag = (a == SBIT) && (&b);
            default: begin
            end
        endcase
    end

    sbv_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start_div),
        .i_cmd   (i_head_ctl.cmd),
        .i_a     (a),
        .i_b     (b),
        .o_stat  (dstat),
        .o_res   (dres),
        .i_take  (div_take)
    );

    assign out_room   = (r_o_cnt != (QPW+1)'(QDEPTH));
    assign s1_move    = r_s1_v && out_room;
    assign s1_ready   = !r_s1_v || s1_move;
    // nothing issues past a division in flight, which keeps results in order
    assign issue      = i_head_v && !i_head_ctl.is_div && dstat.idle && s1_ready;
    assign start_div  = i_head_v && i_head_ctl.is_div && dstat.idle;
    assign div_take   = dstat.done && s1_ready;
    assign o_head_pop = issue || start_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (issue || div_take) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_mk   <= e_mk;
            r_s1_word <= e_word;
            r_s1_flag <= e_flag;
            r_s1_prod <= m_prod;
        end else if (div_take) begin
            r_s1_mk   <= MK_NONE;
            r_s1_word <= dres;
            r_s1_flag <= 1'b0;
        end
    end

    always_comb begin
        f_word = r_s1_word;
        f_flag = r_s1_flag;
        case (r_s1_mk)
            MK_MUL:   f_word = r_s1_prod[WIDTH-1:0];
            MK_UMULO: f_flag = |r_s1_prod[PW-1:WIDTH];
            MK_SMULO: f_flag = !((&r_s1_prod[PW-1:WIDTH-1]) || !(|r_s1_prod[PW-1:WIDTH-1]));
            default: begin
            end
        endcase
    end

    assign o_pop = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_wp  <= '0;
            r_o_rp  <= '0;
            r_o_cnt <= '0;
        end else begin
            if (s1_move) begin
                r_o_wp <= QPW'(r_o_wp + 1'b1);
            end
            if (o_pop) begin
                r_o_rp <= QPW'(r_o_rp + 1'b1);
            end
            r_o_cnt <= (QPW+1)'(r_o_cnt + (QPW+1)'(s1_move) - (QPW+1)'(o_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_word[r_o_wp] <= WORD_W'(f_word);
            r_o_flag[r_o_wp] <= f_flag;
        end
    end

    assign empty         = (r_o_cnt == '0);
    assign o_result_word = r_o_word[r_o_rp];
    assign o_result_flag = r_o_flag[r_o_rp];

endmodule

// ----- sv/smtlib_bitvector_alu.sv -----
// ----------------------------------------------------------------------------
// smtlib_bitvector_alu
// Bit-vector ALU with SMT-LIB semantics behind queue-style handshakes.
// ----------------------------------------------------------------------------
// Commands enter through push/full and results leave through empty/pop, one
// result per command, in command order. All commands except the division
// family (udiv, urem, sdiv, srem, smod) sustain one command per cycle while
// results are popped, and a result passes through the input register,
// command queue, execute register and result queue. A division runs in the
// shared iterative divider, one quotient bit per cycle, and occupies the
// execution side until it is done; commands behind it wait in the two-entry
// queue. Operands use their low WIDTH bits; above 32 bits they are
// zero-extended and the result word carries the low 32 bits.
module smtlib_bitvector_alu
    import sbv_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [WORD_W-1:0] i_operand_a,
    input  logic [WORD_W-1:0] i_operand_b,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] o_result_word,
    output logic              o_result_flag
);

    localparam int unsigned KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             head_v;
    t_ctl             head_ctl;
    logic [WIDTH-1:0] head_a;
    logic [WIDTH-1:0] head_b;
    logic [KW-1:0]    head_k;
    logic             head_pop;

    sbv_front #(
        .WIDTH (WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_cmd       (i_cmd),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_head_v    (head_v),
        .o_head_ctl  (head_ctl),
        .o_head_a    (head_a),
        .o_head_b    (head_b),
        .o_head_k    (head_k),
        .i_head_pop  (head_pop)
    );

    sbv_back #(
        .WIDTH (WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_v      (head_v),
        .i_head_ctl    (head_ctl),
        .i_head_a      (head_a),
        .i_head_b      (head_b),
        .i_head_k      (head_k),
        .o_head_pop    (head_pop),
        .empty         (empty),
        .pop           (pop),
        .o_result_word (o_result_word),
        .o_result_flag (o_result_flag)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bit-vector ALU: a directed table of edge cases,
// then random commands with random push/pop gaps, checked against a predictor.
// ----------------------------------------------------------------------------
module testbench;
    import sbv_pkg::*;

    localparam int unsigned W      = DEF_WIDTH;
    localparam int          N_RAND = 1000;
    localparam int          LIMIT  = 400000;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        bit                known;
        logic [WORD_W-1:0] word;
        logic              flag;
    } t_row;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              flag;
    } t_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              pop = 1'b0;
    logic [CMD_W-1:0]  i_cmd = '0;
    logic [WORD_W-1:0] i_operand_a = '0;
    logic [WORD_W-1:0] i_operand_b = '0;
    logic              full;
    logic              empty;
    logic [WORD_W-1:0] o_result_word;
    logic              o_result_flag;

    t_res pending_q[$];
    t_row dir_tbl[$];
    int   n_err = 0;
    int   cyc = 0;
    bit   pop_calm = 1'b0;

    smtlib_bitvector_alu #(.WIDTH(W)) dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic bit s_lt(logic [W-1:0] x, logic [W-1:0] y);
        return $signed(x) < $signed(y);
    endfunction

    function automatic t_res alu_calc(logic [CMD_W-1:0] c, logic [W-1:0] a,
                                      logic [W-1:0] b);
        localparam logic [W-1:0] MSB = {1'b1, {(W-1){1'b0}}};
        t_res r;
        logic [W-1:0] ma, mb, q, rm, k;
        logic [2*W-1:0] p;
        logic [2*W+1:0] sp;
        r.word = '0;
        r.flag = 1'b0;
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        case (c)
            CMD_NOT:  r.word = ~a;
            CMD_AND:  r.word = a & b;
            CMD_OR:   r.word = a | b;
            CMD_XOR:  r.word = a ^ b;
            CMD_NAND: r.word = ~(a & b);
            CMD_NOR:  r.word = ~(a | b);
            CMD_XNOR: r.word = ~(a ^ b);
            CMD_NEG:  r.word = -a;
            CMD_ADD:  r.word = a + b;
            CMD_SUB:  r.word = a - b;
            CMD_MUL:  r.word = a * b;
            CMD_UDIV: r.word = (b == 0) ? '1 : a / b;
            CMD_UREM: r.word = (b == 0) ? a : a % b;
            CMD_SDIV: begin
                if (b == 0) r.word = '1;
                else if (a == MSB && b == '1) r.word = a;
                else begin
                    q = ma / mb;
                    r.word = (a[W-1] ^ b[W-1]) ? -q : q;
                end
            end
            CMD_SREM, CMD_SMOD: begin
                if (b == 0) r.word = a;
                else if (a == MSB && b == '1) r.word = '0;
                else begin
                    rm = ma % mb;
                    if (a[W-1]) rm = -rm;
                    if (c == CMD_SMOD && rm != 0 && (rm[W-1] ^ b[W-1])) rm = rm + b;
                    r.word = rm;
                end
            end
            CMD_SHL:  r.word = (b >= W) ? '0 : a << b;
            CMD_LSHR: r.word = (b >= W) ? '0 : a >> b;
            CMD_ASHR: r.word = (b >= W) ? {W{a[W-1]}} : W'($signed(a) >>> b);
            CMD_ROTL: begin
                k = b % W;
                r.word = (k == 0) ? a : (a << k) | (a >> (W - k));
            end
            CMD_ROTR: begin
                k = b % W;
                r.word = (k == 0) ? a : (a >> k) | (a << (W - k));
            end
            CMD_ULT, CMD_USUBO: r.flag = a < b;
            CMD_ULE:    r.flag = a <= b;
            CMD_UGT:    r.flag = a > b;
            CMD_UGE:    r.flag = a >= b;
            CMD_SLT:    r.flag = s_lt(a, b);
            CMD_SLE:    r.flag = !s_lt(b, a);
            CMD_SGT:    r.flag = s_lt(b, a);
            CMD_SGE:    r.flag = !s_lt(a, b);
            CMD_EQ:     r.flag = a == b;
            CMD_REDAND: r.flag = &a;
            CMD_REDOR:  r.flag = |a;
            CMD_NEGO:   r.flag = a == MSB;
            CMD_UADDO:  r.flag = W'(a + b) < a;
            CMD_SADDO: begin
                k = a + b;
                r.flag = (a[W-1] == b[W-1]) && (k[W-1] != a[W-1]);
            end
            CMD_UMULO: begin
                p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
                r.flag = p[2*W-1:W] != 0;
            end
            CMD_SMULO: begin
                // full signed product must fit in W bits
                sp = $signed({{(W+2){a[W-1]}}, a}) * $signed({{(W+2){b[W-1]}}, b});
                r.flag = $signed(sp) != $signed({{(W+2){sp[W-1]}}, sp[W-1:0]});
            end
            CMD_SSUBO: begin
                k = a - b;
                r.flag = (a[W-1] != b[W-1]) && (k[W-1] != a[W-1]);
            end
            CMD_SDIVO:  r.flag = (a == MSB) && (b == '1);
            default: ;
        endcase
        return r;
    endfunction

    // result side: random pop gaps, checked at the transfer edge
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (pending_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result word=%h flag=%b", o_result_word,
                                 o_result_flag);
                end else begin
                    exp_r = pending_q.pop_front();
                    if (o_result_word !== exp_r.word || o_result_flag !== exp_r.flag) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp word=%h flag=%b got word=%h flag=%b",
                                     exp_r.word, exp_r.flag, o_result_word,
                                     o_result_flag);
                    end
                end
            end
            pop <= pop_calm || ($urandom_range(99) >= 25);
        end
    end

    task automatic send_cmd(logic [CMD_W-1:0] c, logic [WORD_W-1:0] a,
                            logic [WORD_W-1:0] b, bit calm);
        t_res r;
        while (!calm && $urandom_range(99) < 25) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= c;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        r = alu_calc(c, a[W-1:0], b[W-1:0]);
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic add_row(logic [CMD_W-1:0] c, logic [WORD_W-1:0] a,
                           logic [WORD_W-1:0] b, bit known = 0,
                           logic [WORD_W-1:0] w = '0, logic f = 1'b0);
        t_row rw;
        rw.cmd = c; rw.a = a; rw.b = b; rw.known = known; rw.word = w; rw.flag = f;
        dir_tbl.insert(dir_tbl.size(), rw);
    endtask

    function automatic logic [WORD_W-1:0] rnd_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(40);
            5: return -$urandom_range(4);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        t_row rw;
        logic [CMD_W-1:0] c;
        bit hold;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(CMD_UDIV, 32'h1234, 0, 1, '1, 0);
        add_row(CMD_UREM, 32'h1234, 0, 1, 32'h1234, 0);
        add_row(CMD_SDIV, 32'h8000_0000, '1, 1, 32'h8000_0000, 0);
        add_row(CMD_SREM, 32'h8000_0000, '1, 1, 0, 0);
        add_row(CMD_SMOD, 32'h8000_0000, '1, 1, 0, 0);
        add_row(CMD_SDIV, 5, 0, 1, '1, 0);
        add_row(CMD_SMOD, 32'hffff_fff9, 0, 1, 32'hffff_fff9, 0);
        add_row(CMD_SHL, '1, 32, 1, 0, 0);
        add_row(CMD_LSHR, '1, '1, 1, 0, 0);
        add_row(CMD_ASHR, 32'h8000_0000, 40, 1, '1, 0);
        add_row(CMD_ROTL, 32'h8000_0001, 33);
        add_row(CMD_ROTR, 32'h8000_0001, 64, 1, 32'h8000_0001, 0);
        add_row(CMD_SDIVO, 32'h8000_0000, '1, 1, 0, 1);
        add_row(CMD_NEGO, 32'h8000_0000, 0, 1, 0, 1);
        add_row(CMD_REDAND, '1, 0, 1, 0, 1);
        add_row(CMD_SMULO, 32'h8000_0000, 1);
        add_row(CMD_SMULO, 32'h8000_0000, '1);
        add_row(CMD_UMULO, '1, '1);
        add_row(CMD_SADDO, 32'h7fff_ffff, 1);
        add_row(CMD_SSUBO, 32'h8000_0000, 1);
        add_row(CMD_SMOD, 32'hffff_fff9, 3);
        add_row(CMD_W'(40), '1, '1, 1, 0, 0);
        add_row(CMD_W'(63), '1, '1, 1, 0, 0);

        while (dir_tbl.size() > 0) begin
            rw = dir_tbl.pop_front();
            send_cmd(rw.cmd, rw.a, rw.b, 0);
            if (rw.known) pending_q[$] = '{word: rw.word, flag: rw.flag};
        end
        // every opcode with random operands
        for (int i = 0; i < 40; i++) send_cmd(CMD_W'(i), $urandom, $urandom, 0);

        for (int i = 0; i < N_RAND; i++) begin
            hold = (i >= 400 && i < 550);
            pop_calm = hold;
            c = ($urandom_range(19) == 0) ? CMD_W'($urandom_range(63))
                                          : CMD_W'($urandom_range(39));
            send_cmd(c, rnd_operand(), rnd_operand(), hold);
        end
        pop_calm = 1'b0;
        push <= 1'b0;

        while (pending_q.size() > 0) @(posedge i_clk);
        repeat (W + 20) @(posedge i_clk);
        if (n_err == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
